// ===== rtl/core/stt_pkg.sv =====
// Shared constants for the sparse triple transpose block.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int CAPACITY = 64;
    localparam int MAX_DIM  = 256;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int DIM_W   = 9;
    localparam int VAL_W   = 32;
    localparam int ENTRY_W = 2 * DIM_W + VAL_W;
    localparam int TDATA_W = ((ENTRY_W + 7) / 8) * 8;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
    } t_entry;

endpackage

// ===== rtl/core/sparse_triple_transpose.sv =====
// Sparse matrix triplet transpose: loads triples into a RAM, emits them by column.
// Load: one request per cycle into the entry RAM, no result until the last one.
// Emission walk: one pass over the stored entries per distinct in-range column plus
//   one seek pass; each pass reads every stored entry through the single RAM read port.
// Output register: a result reaches o_m_axis_* one match later (or at walk end).
// Reset: synchronous, active low; clears count, flags and state, not the RAM.
`timescale 1ns / 1ps

module sparse_triple_transpose
    import stt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: num_cols
    input  logic               i_cfg_we,
    input  logic [DIM_W-1:0]   i_cfg_wdata,
    // input requests
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,  // in_row, in_col, in_value, zero pad
    input  logic               i_s_axis_tuser,  // has_entry
    input  logic               i_s_axis_tlast,  // last_entry
    // results
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,  // out_row, out_col, out_value, zero pad
    output logic               o_m_axis_tuser,  // overflow
    output logic               o_m_axis_tlast   // out_last
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    t_entry mem [CAPACITY];

    logic [1:0]       r_state, n_state;
    logic [DIM_W-1:0] r_num_cols;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_dropped, n_dropped;
    logic             r_scan_ovf, n_scan_ovf;
    logic [DIM_W-1:0] r_limit, n_limit;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic [DIM_W-1:0] r_cur, n_cur;
    logic [DIM_W-1:0] r_next, n_next;
    logic             r_next_v, n_next_v;
    logic             r_rvalid, n_rvalid;
    t_entry           r_rdata;
    t_entry           r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    t_entry           r_out, n_out;
    logic             r_out_v, n_out_v;
    logic             r_out_last, n_out_last;
    logic             r_out_ovf, n_out_ovf;

    t_entry in_ent;
    logic   accept, wr_en, full, out_free, match, stall, issue, pass_end, cand, out_load;

    assign in_ent   = t_entry'(i_s_axis_tdata[ENTRY_W-1:0]);
    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign wr_en    = accept && i_s_axis_tuser && !full;
    assign out_free = !r_out_v || i_m_axis_tready;

    assign match    = (r_cur != '0) && (r_rdata.col == r_cur);
    assign stall    = r_rvalid && match && r_pend_v && !out_free;
    assign issue    = (r_state == ST_SCAN) && !stall && (r_addr != r_count);
    assign pass_end = (r_state == ST_SCAN) && (r_addr == r_count) && !r_rvalid;
    // candidate for the next column to visit: smallest in-range column above current
    assign cand     = (r_rdata.col != '0) && (r_rdata.col > r_cur)
                   && (r_rdata.col <= r_limit) && (!r_next_v || (r_rdata.col < r_next));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_scan_ovf = r_scan_ovf;
        n_limit    = r_limit;
        n_addr     = r_addr;
        n_cur      = r_cur;
        n_next     = r_next;
        n_next_v   = r_next_v;
        n_rvalid   = stall ? r_rvalid : issue;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        out_load   = 1'b0;

        if (issue) begin
            n_addr = r_addr + 1'b1;
        end

        // push a match through the one-deep lookahead so out_last is known
        if (r_rvalid && !stall) begin
            if (match) begin
                if (r_pend_v) begin
                    out_load   = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b0;
                end
                n_pend   = r_rdata;
                n_pend_v = 1'b1;
            end
            if (cand) begin
                n_next   = r_rdata.col;
                n_next_v = 1'b1;
            end
        end

        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (wr_en) begin
                        n_count = r_count + 1'b1;
                    end else if (i_s_axis_tuser) begin
                        n_dropped = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_scan_ovf = r_dropped || (i_s_axis_tuser && full);
                        n_dropped  = 1'b0;
                        n_limit    = (r_num_cols > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                                    : r_num_cols;
                        n_addr     = '0;
                        n_cur      = '0;
                        n_next_v   = 1'b0;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (pass_end) begin
                    n_addr = '0;
                    if (r_next_v) begin
                        n_cur    = r_next;
                        n_next_v = 1'b0;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_pend_v) begin
                    n_count = '0;
                    n_state = ST_LOAD;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_count    = '0;
                    n_state    = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        n_out_v   = out_load ? 1'b1 : (r_out_v && !i_m_axis_tready);
        // overflow travels with the result; the next load may close while it waits
        n_out_ovf = out_load ? r_scan_ovf : r_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_num_cols <= DIM_W'(1);
            r_count    <= '0;
            r_dropped  <= 1'b0;
            r_scan_ovf <= 1'b0;
            r_limit    <= '0;
            r_addr     <= '0;
            r_cur      <= '0;
            r_next     <= '0;
            r_next_v   <= 1'b0;
            r_rvalid   <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_cols <= i_cfg_wdata;
            end
            r_state    <= n_state;
            r_count    <= n_count;
            r_dropped  <= n_dropped;
            r_scan_ovf <= n_scan_ovf;
            r_limit    <= n_limit;
            r_addr     <= n_addr;
            r_cur      <= n_cur;
            r_next     <= n_next;
            r_next_v   <= n_next_v;
            r_rvalid   <= n_rvalid;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
            r_out_last <= n_out_last;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend    <= n_pend;
        r_out     <= n_out;
        r_out_ovf <= n_out_ovf;
    end

    // entry RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[ADDR_W-1:0]] <= in_ent;
        end
        if (issue) begin
            r_rdata <= mem[r_addr[ADDR_W-1:0]];
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {(TDATA_W - ENTRY_W)'(0), r_out.value, r_out.row, r_out.col};
    assign o_m_axis_tuser  = r_out_ovf;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/core/stt_checker.sv =====
// Port-level checker for the sparse triple transpose block, with its bind.
`timescale 1ns / 1ps

module stt_checker
    import stt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic               i_s_axis_tlast,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [TDATA_W-1:0] o_m_axis_tdata,
    input logic               o_m_axis_tuser,
    input logic               o_m_axis_tlast
);

    logic             r_in_run;
    logic [DIM_W-1:0] r_prev_row;
    logic             r_prev_ovf;
    logic             out_xfer;

    assign out_xfer = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (out_xfer) begin
            r_in_run <= !o_m_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_prev_row <= o_m_axis_tdata[DIM_W-1:0];
            r_prev_ovf <= o_m_axis_tuser;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
             && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    // emitted rows follow source column order within a run
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_in_run) |-> (o_m_axis_tdata[DIM_W-1:0] >= r_prev_row))
        else $error("transposed rows out of order");

    // overflow flag is constant across one run
    a_ovf_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_in_run) |-> (o_m_axis_tuser == r_prev_ovf))
        else $error("overflow flag changed inside a run");

    // never a column zero entry on the output
    a_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[DIM_W-1:0] != '0))
        else $error("emitted entry from column zero");

    // closing request stops loading while the walk runs
    a_load_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input taken right after closing request");

endmodule

bind sparse_triple_transpose stt_checker u_stt_checker (.*);
